FILE: rtl/scs_pkg.sv
// Package for the stable counting sort core: field widths, register map,
// controller states and the command and status bundles. No dependencies.
`default_nettype none

package scs_pkg;

  localparam int KEY_W   = 8;   // fitness key width
  localparam int PAY_W   = 32;  // payload word width
  localparam int LIM_W   = 9;   // key limit register width
  localparam int CNT_W   = 7;   // histogram entry width
  localparam int ITEM_W  = KEY_W + PAY_W;
  localparam int DATA_W  = 32;  // configuration data bus width
  localparam int PADDR_W = 3;   // configuration address width

  localparam logic [PADDR_W-3:0] REG_KEY_LIMIT = 1'b0;
  localparam logic [LIM_W-1:0]   KEY_LIMIT_RST = 9'd256;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_HIST_RD,
    ST_HIST_CNT,
    ST_HIST_WR,
    ST_PFX,
    ST_PLC_RD,
    ST_PLC_POS,
    ST_PLC_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } scs_state_t;

  typedef struct packed {
    logic clr_wr;      // zero one histogram entry during the reset sweep
    logic load_wr;     // an input word is accepted
    logic hist_cnt;    // histogram read at the fetched key
    logic hist_wr;     // histogram increment write-back
    logic pfx;         // running-sum sweep
    logic plc_rd;      // fetch buffered item idx-1
    logic plc_pos;     // position read at the fetched key
    logic plc_wr;      // position decrement and sorted store write
    logic emit_ld;     // load the output register
    logic emit_adv;    // output word taken, move on
    logic ctr_rst;     // key counter and running sum back to zero
    logic idx_rst;     // item index to zero
    logic idx_load_n;  // item index to item count
    logic cnt_rst;     // item count to zero
  } scs_cmd_t;

  typedef struct packed {
    logic idx_is_last;
    logic idx_is_one;
    logic clr_last;
    logic pfx_done;
    logic out_taken;
  } scs_stat_t;

endpackage

`default_nettype wire

FILE: rtl/stable_counting_sort_core.sv
// Top level of the stable counting sort core: configuration register port,
// sequencer and datapath. Depends on scs_pkg, scs_ctrl, scs_dp, scs_ram.
//
//   Channel  Dir  Handshake            Word fields
//   in_      in   in_valid/in_ready    fitness_key, payload, last_in
//   out_     out  out_valid/out_ready  sorted_key, sorted_payload, last_out
//   config   in   psel/penable/pwrite  key_limit at address 0; pready tied high
//
// After reset the histogram RAM is swept to zero, one entry a cycle; no input
// word is taken meanwhile (config writes are). Loading takes one word a cycle.
// A batch then goes through histogram read-modify-write, a running-sum sweep
// over the key range, placement and output. The histogram and position RAMs
// each have one read and one write port. A stalled output word holds in its
// register; the next batch is taken only after the final word of the previous
// one has been accepted.
`default_nettype none

module stable_counting_sort_core
  import scs_pkg::*;
#(
  parameter int MAX_ITEMS  = 64,
  parameter int KEY_VALUES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel.
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [KEY_W-1:0]   in_fitness_key,
  input  wire logic [PAY_W-1:0]   in_payload,
  input  wire logic               in_last_in,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [KEY_W-1:0]   out_sorted_key,
  output logic      [PAY_W-1:0]   out_sorted_payload,
  output logic                    out_last_out,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  logic [LIM_W-1:0] key_limit_r, key_limit_nxt;
  logic             reg_sel;
  scs_cmd_t         cmd;
  scs_stat_t        st;

  // The register index sits above the byte offset within a 32-bit word.
  assign reg_sel = paddr[PADDR_W-1:2] == REG_KEY_LIMIT;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DATA_W'(key_limit_r) : '0;

  // The write lands in the access phase; writes to other addresses are dropped.
  always_comb begin
    key_limit_nxt = key_limit_r;
    if (psel && penable && pwrite && reg_sel) begin
      key_limit_nxt = pwdata[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= KEY_LIMIT_RST;
    end else begin
      key_limit_r <= key_limit_nxt;
    end
  end

  scs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last_in),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  scs_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .KEY_VALUES (KEY_VALUES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_fitness_key     (in_fitness_key),
    .in_payload         (in_payload),
    .key_limit          (key_limit_r),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_sorted_key     (out_sorted_key),
    .out_sorted_payload (out_sorted_payload),
    .out_last_out       (out_last_out)
  );

endmodule

`default_nettype wire

FILE: rtl/scs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/scs_ctrl.sv
// Sequencer of the stable counting sort core: one state machine that steps
// the datapath through clear, load, histogram, running sum, placement, output.
// Depends on scs_pkg.
`default_nettype none

module scs_ctrl
  import scs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  input  wire scs_stat_t st,
  output scs_cmd_t       cmd
);

  scs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (st.clr_last) state_nxt = ST_LOAD;
      ST_LOAD:      if (in_valid && in_last) state_nxt = ST_HIST_RD;
      ST_HIST_RD:   state_nxt = ST_HIST_CNT;
      ST_HIST_CNT:  state_nxt = ST_HIST_WR;
      ST_HIST_WR:   state_nxt = st.idx_is_last ? ST_PFX : ST_HIST_RD;
      ST_PFX:       if (st.pfx_done) state_nxt = ST_PLC_RD;
      ST_PLC_RD:    state_nxt = ST_PLC_POS;
      ST_PLC_POS:   state_nxt = ST_PLC_WR;
      ST_PLC_WR:    state_nxt = st.idx_is_one ? ST_EMIT_RD : ST_PLC_RD;
      ST_EMIT_RD:   state_nxt = ST_EMIT_LD;
      ST_EMIT_LD:   state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (st.out_taken) begin
          state_nxt = st.idx_is_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.ctr_rst = st.clr_last;
      end
      ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.load_wr = in_valid;
        cmd.idx_rst = in_valid && in_last;
      end
      ST_HIST_RD:  ;
      ST_HIST_CNT: cmd.hist_cnt = 1'b1;
      ST_HIST_WR:  cmd.hist_wr = 1'b1;
      ST_PFX: begin
        cmd.pfx        = 1'b1;
        cmd.ctr_rst    = st.pfx_done;
        cmd.idx_load_n = st.pfx_done;
      end
      ST_PLC_RD:  cmd.plc_rd = 1'b1;
      ST_PLC_POS: cmd.plc_pos = 1'b1;
      ST_PLC_WR: begin
        cmd.plc_wr  = 1'b1;
        cmd.idx_rst = st.idx_is_one;
      end
      ST_EMIT_RD: ;
      ST_EMIT_LD: cmd.emit_ld = 1'b1;
      ST_EMIT_WAIT: begin
        cmd.emit_adv = st.out_taken;
        cmd.cnt_rst  = st.out_taken && st.idx_is_last;
      end
      default: ;
    endcase
  end

  // An output word can only be taken while the sequencer waits for it.
  a_taken_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.out_taken |-> state_r == ST_EMIT_WAIT)
    else $error("output word taken outside the output wait state");

endmodule

`default_nettype wire

FILE: rtl/scs_dp.sv
// Datapath of the stable counting sort core: item buffer, histogram and
// position RAMs, sorted store, counters and the output register.
// Depends on scs_pkg and scs_ram.
`default_nettype none

module scs_dp
  import scs_pkg::*;
#(
  parameter int MAX_ITEMS  = 64,
  parameter int KEY_VALUES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scs_cmd_t          cmd,
  output scs_stat_t              st,
  input  wire logic [KEY_W-1:0]  in_fitness_key,
  input  wire logic [PAY_W-1:0]  in_payload,
  input  wire logic [LIM_W-1:0]  key_limit,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [KEY_W-1:0]  out_sorted_key,
  output logic      [PAY_W-1:0]  out_sorted_payload,
  output logic                   out_last_out
);

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int N_W    = $clog2(MAX_ITEMS + 1);
  localparam int KIDX_W = $clog2(KEY_VALUES);
  localparam int KC_W   = $clog2(KEY_VALUES + 1);

  logic [N_W-1:0]    cnt_r, cnt_nxt;
  logic [N_W-1:0]    idx_r, idx_nxt;
  logic [KC_W-1:0]   kctr_r, kctr_nxt;
  logic              pv_r;
  logic [KIDX_W-1:0] pk_r;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [KIDX_W-1:0] key_r;
  logic [PAY_W-1:0]  pay_r;
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [PAY_W-1:0]  out_pay_r;
  logic              out_last_r;

  logic [LIM_W-1:0]  lim;
  logic [KEY_W-1:0]  key_c;
  logic              buf_we;
  logic [IDX_W-1:0]  buf_raddr;
  logic [ITEM_W-1:0] buf_rdata;
  logic [KIDX_W-1:0] buf_kidx;
  logic              issue;
  logic              a_we;
  logic [KIDX_W-1:0] a_waddr, a_raddr;
  logic [CNT_W-1:0]  a_wdata, a_rdata;
  logic              b_we;
  logic [KIDX_W-1:0] b_waddr;
  logic [CNT_W-1:0]  b_wdata, b_rdata;
  logic [CNT_W-1:0]  pos;
  logic [ITEM_W-1:0] srt_rdata;

  // Key clamp against the limit in force at load time.
  always_comb begin
    if (key_limit == '0) begin
      lim = LIM_W'(1);
    end else if (32'(key_limit) > KEY_VALUES) begin
      lim = LIM_W'(KEY_VALUES);
    end else begin
      lim = key_limit;
    end
    key_c = ({1'b0, in_fitness_key} >= lim) ? KEY_W'(lim - 1'b1) : in_fitness_key;
  end

  assign buf_we    = cmd.load_wr && (cnt_r < N_W'(MAX_ITEMS));
  assign buf_raddr = cmd.plc_rd ? IDX_W'(idx_r - 1'b1) : idx_r[IDX_W-1:0];
  assign buf_kidx  = KIDX_W'(buf_rdata[ITEM_W-1:PAY_W]);

  scs_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({key_c, in_payload}),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Histogram: counted per key, then swept into running sums and zeroed.
  assign issue   = cmd.pfx && (kctr_r != KC_W'(KEY_VALUES));
  assign a_raddr = issue ? kctr_r[KIDX_W-1:0] : buf_kidx;
  assign sum_nxt = sum_r + a_rdata;

  always_comb begin
    a_we    = 1'b0;
    a_waddr = kctr_r[KIDX_W-1:0];
    a_wdata = '0;
    if (cmd.clr_wr) begin
      a_we = 1'b1;
    end else if (cmd.hist_wr) begin
      a_we    = 1'b1;
      a_waddr = key_r;
      a_wdata = a_rdata + 1'b1;
    end else if (pv_r) begin
      a_we    = 1'b1;
      a_waddr = pk_r;
    end
  end

  scs_ram #(.WIDTH(CNT_W), .DEPTH(KEY_VALUES)) u_hist (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Positions: inclusive running sums, counted down as items are placed.
  assign pos = b_rdata - 1'b1;

  always_comb begin
    b_we    = 1'b0;
    b_waddr = pk_r;
    b_wdata = sum_nxt;
    if (pv_r) begin
      b_we = 1'b1;
    end else if (cmd.plc_wr) begin
      b_we    = 1'b1;
      b_waddr = key_r;
      b_wdata = pos;
    end
  end

  scs_ram #(.WIDTH(CNT_W), .DEPTH(KEY_VALUES)) u_pos (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (buf_kidx),
    .rdata (b_rdata)
  );

  scs_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_sorted (
    .clk   (clk),
    .we    (cmd.plc_wr),
    .waddr (pos[IDX_W-1:0]),
    .wdata ({KEY_W'(key_r), pay_r}),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (srt_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_rst) begin
      cnt_nxt = '0;
    end else if (buf_we) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    idx_nxt = idx_r;
    if (cmd.idx_rst) begin
      idx_nxt = '0;
    end else if (cmd.idx_load_n) begin
      idx_nxt = cnt_r;
    end else if (cmd.hist_wr || cmd.emit_adv) begin
      idx_nxt = idx_r + 1'b1;
    end else if (cmd.plc_wr) begin
      idx_nxt = idx_r - 1'b1;
    end

    kctr_nxt = kctr_r;
    if (cmd.ctr_rst) begin
      kctr_nxt = '0;
    end else if (cmd.clr_wr || issue) begin
      kctr_nxt = kctr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      kctr_r      <= '0;
      pv_r        <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      kctr_r <= kctr_nxt;
      pv_r   <= issue;
      if (cmd.ctr_rst) begin
        sum_r <= '0;
      end else if (pv_r) begin
        sum_r <= sum_nxt;
      end
      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pk_r <= kctr_r[KIDX_W-1:0];
    if (cmd.hist_cnt || cmd.plc_pos) begin
      key_r <= buf_kidx;
      pay_r <= buf_rdata[PAY_W-1:0];
    end
    if (cmd.emit_ld) begin
      out_key_r  <= srt_rdata[ITEM_W-1:PAY_W];
      out_pay_r  <= srt_rdata[PAY_W-1:0];
      out_last_r <= st.idx_is_last;
    end
  end

  assign st.idx_is_last = (idx_r + 1'b1) == cnt_r;
  assign st.idx_is_one  = idx_r == N_W'(1);
  assign st.clr_last    = kctr_r == KC_W'(KEY_VALUES - 1);
  assign st.pfx_done    = (kctr_r == KC_W'(KEY_VALUES)) && !pv_r;
  assign st.out_taken   = out_valid_r && out_ready;

  assign out_valid          = out_valid_r;
  assign out_sorted_key     = out_key_r;
  assign out_sorted_payload = out_pay_r;
  assign out_last_out       = out_last_r;

  // Every placed item finds a nonzero running sum for its key.
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.plc_wr |-> b_rdata != '0)
    else $error("placement found an empty key slot");

  // The item count never runs past the buffer depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= N_W'(MAX_ITEMS))
    else $error("item count beyond buffer depth");

  // No input is taken while a sorted word is still pending on the output.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> !out_valid_r)
    else $error("input accepted while output word pending");

endmodule

`default_nettype wire

FILE: test/stable_counting_sort_core_tb.sv
// Self-checking testbench for stable_counting_sort_core: directed and random batches
// are checked against an in-bench stable counting sort predictor.
// Depends on scs_pkg and the core RTL only.
`timescale 1ns / 1ps

module stable_counting_sort_core_tb;
  import scs_pkg::*;

  localparam int MAX_ITEMS     = 64;
  localparam int KEY_VALUES    = 256;
  localparam int RANDOM_ITEMS  = 270;
  // Quiet cycles to let pass before a register write once nothing is owed.
  localparam int SETTLE_CYCLES = 20;
  // Quiet cycles at the end, enough for a full histogram sweep and more.
  localparam int END_QUIET     = KEY_VALUES + 64;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT   = 5000;
  localparam int REPORT_MAX    = 10;

  // The key limit sits at word 0; word 1 is unmapped and must be ignored.
  localparam logic [PADDR_W-1:0] ADDR_KEY_LIMIT = {REG_KEY_LIMIT, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = ADDR_KEY_LIMIT + PADDR_W'(4);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             last;
  } sorted_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KEY_W-1:0]   in_fitness_key = '0;
  logic [PAY_W-1:0]   in_payload = '0;
  logic               in_last_in = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KEY_W-1:0]   out_sorted_key;
  logic [PAY_W-1:0]   out_sorted_payload;
  logic               out_last_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Predictor state: the limit as the block should hold it, the batch being
  // loaded (keys already clamped), and the sorted words still owed.
  logic [LIM_W-1:0]   limit_shadow = KEY_LIMIT_RST;
  logic [KEY_W-1:0]   batch_keys[$];
  logic [PAY_W-1:0]   batch_pays[$];
  sorted_word_t       expected_words[$];
  sorted_word_t       got_word;
  sorted_word_t       want_word;
  int                 error_count = 0;

  // Traffic shaping. tx_free and rx_free turn off idling on either side;
  // hold_len asks the receiver for one long hold-off of that many cycles.
  bit                 tx_free = 1'b0;
  bit                 rx_free = 1'b0;
  int                 hold_len = 0;
  int                 burst_left = 0;

  stable_counting_sort_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_VALUES(KEY_VALUES)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_fitness_key    (in_fitness_key),
    .in_payload        (in_payload),
    .in_last_in        (in_last_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sorted_key    (out_sorted_key),
    .out_sorted_payload(out_sorted_payload),
    .out_last_out      (out_last_out),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Clamp a key by the limit in force right now. A limit of zero behaves as
  // one, and anything above the key range behaves as the full key range.
  function automatic logic [KEY_W-1:0] limit_key(input logic [KEY_W-1:0] key);
    int lim;
    lim = limit_shadow;
    if (lim == 0) lim = 1;
    if (lim > KEY_VALUES) lim = KEY_VALUES;
    if (int'(key) >= lim) return KEY_W'(lim - 1);
    return key;
  endfunction

  // Offer one input word and hold it until it is taken. On acceptance the
  // word goes into the predicted batch; a word with last_in closes the batch
  // and the stable ascending order is queued as expected output. Words past
  // MAX_ITEMS are dropped, but their last_in still closes the batch.
  // Between bursts the sender drops valid for a random gap.
  task automatic send_word(input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay,
                           input logic last);
    int gap;
    int n;
    int pos;
    in_valid       <= 1'b1;
    in_fitness_key <= key;
    in_payload     <= pay;
    in_last_in     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (batch_keys.size() < MAX_ITEMS) begin
      batch_keys.push_back(limit_key(key));
      batch_pays.push_back(pay);
    end
    if (last) begin
      // Walking key values upward and, within one key, the batch in arrival
      // order gives exactly the order of a stable counting sort.
      n   = batch_keys.size();
      pos = 0;
      for (int k = 0; k < KEY_VALUES; k++) begin
        for (int i = 0; i < n; i++) begin
          if (int'(batch_keys[i]) == k) begin
            expected_words.push_back('{key: batch_keys[i], payload: batch_pays[i],
                                       last: (pos == n - 1)});
            pos++;
          end
        end
      end
      batch_keys.delete();
      batch_pays.delete();
    end
    if (!tx_free) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // Stop offering, wait until every owed word has come out, then let the
  // block settle so that a register write finds it idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is expected high.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_KEY_LIMIT) limit_shadow = data[LIM_W-1:0];
  endtask

  // Reset limit of 256: extreme keys and payloads, repeated keys to check
  // stability, and a batch of a single word.
  task automatic test_default_limit();
    send_word(8'd255, 32'hFFFF_FFFF, 1'b0);
    send_word(8'd0,   32'h0000_0000, 1'b0);
    send_word(8'd255, 32'hAAAA_AAAA, 1'b0);
    send_word(8'd0,   32'h5555_5555, 1'b0);
    send_word(8'd128, 32'h0000_0001, 1'b0);
    send_word(8'd0,   32'h8000_0000, 1'b1);
    send_word(8'd255, 32'hFFFF_FFFF, 1'b1);
  endtask

  // A zero limit folds every key to 0, so arrival order must survive; a limit
  // above the key range acts as the full range; a limit of one folds to 0.
  task automatic test_limit_extremes();
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'd0);
    send_word(8'd255, 32'h1111_1111, 1'b0);
    send_word(8'd7,   32'h2222_2222, 1'b0);
    send_word(8'd0,   32'h3333_3333, 1'b1);
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'hFFFF_FFFF);
    send_word(8'd255, 32'h4444_4444, 1'b0);
    send_word(8'd254, 32'h5555_5555, 1'b1);
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'd1);
    send_word(8'd9,   32'h6666_6666, 1'b0);
    send_word(8'd0,   32'h7777_7777, 1'b1);
  endtask

  // A write to the unmapped word must leave the key limit as it was.
  task automatic test_unmapped_register();
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'd10);
    write_reg(ADDR_UNMAPPED, 32'd3);
    send_word(8'd200, 32'hDEAD_0001, 1'b0);
    send_word(8'd3,   32'hDEAD_0002, 1'b0);
    send_word(8'd9,   32'hDEAD_0003, 1'b1);
  endtask

  // Keys are clamped by the limit in force when they are loaded, so changing
  // the limit in the middle of a batch affects only the later words.
  task automatic test_clamp_at_load();
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'd256);
    send_word(8'd200, 32'hC0DE_0001, 1'b0);
    send_word(8'd100, 32'hC0DE_0002, 1'b0);
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'd50);
    send_word(8'd200, 32'hC0DE_0003, 1'b1);
  endtask

  // A full batch, then one that runs past capacity: the surplus is dropped
  // and the closing word, itself dropped, still starts the sort.
  task automatic test_batch_overflow();
    wait_drained();
    write_reg(ADDR_KEY_LIMIT, 32'd256);
    for (int i = 0; i < MAX_ITEMS; i++) begin
      send_word(KEY_W'($urandom_range(0, 255)), $urandom, i == MAX_ITEMS - 1);
    end
    for (int i = 0; i < MAX_ITEMS + 3; i++) begin
      send_word(KEY_W'($urandom_range(0, 15)), $urandom, i == MAX_ITEMS + 2);
    end
  endtask

  // The receiver holds off long enough that the first batch is sorted and
  // stuck at the output while the sender keeps offering the next batch, which
  // the block must refuse until the final word of the first has gone out.
  task automatic test_output_backpressure();
    wait_drained();
    hold_len <= 1200;
    for (int i = 0; i < 48; i++) begin
      send_word(KEY_W'($urandom_range(0, 255)), $urandom, i == 23 || i == 47);
    end
  endtask

  // Random batches, mostly short, some medium and a few past capacity, under
  // random limits and key patterns that stress clamping and stability.
  task automatic test_random_batches();
    int stored;
    int n;
    int pick;
    int key_style;
    int lim;
    int base;
    int kv;
    logic [DATA_W-1:0] data;
    stored = 0;
    while (stored < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        data = $urandom;
        case ($urandom_range(0, 7))
          0:       data[LIM_W-1:0] = '0;
          1:       data[LIM_W-1:0] = LIM_W'(1);
          2:       data[LIM_W-1:0] = KEY_LIMIT_RST;
          3:       data[LIM_W-1:0] = LIM_W'($urandom_range(257, 511));
          default: data[LIM_W-1:0] = LIM_W'($urandom_range(2, 255));
        endcase
        write_reg(ADDR_KEY_LIMIT, data);
      end
      tx_free = ($urandom_range(0, 4) == 0);
      rx_free <= ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 75) n = $urandom_range(1, 12);
      else if (pick < 95) n = $urandom_range(13, 40);
      else n = $urandom_range(60, 70);
      lim = (limit_shadow == 0) ? 1 : int'(limit_shadow);
      if (lim > KEY_VALUES) lim = KEY_VALUES;
      key_style = $urandom_range(0, 3);
      base = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
        case (key_style)
          0: kv = $urandom_range(0, 255);
          1: kv = base + $urandom_range(0, 3);
          2: kv = $urandom_range((lim > 2) ? lim - 2 : 0, 255);
          default: kv = ($urandom_range(0, 1) != 0) ? 255 : 0;
        endcase
        if (kv > 255) kv = 255;
        send_word(KEY_W'(kv), $urandom, i == n - 1);
      end
      stored += (n < MAX_ITEMS) ? n : MAX_ITEMS;
      // Now and then the sender waits for the whole backlog to drain.
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    tx_free = 1'b0;
    rx_free <= 1'b0;
  endtask

  // Receiver: runs of ready broken by short stalls, sometimes longer ones,
  // plus the long hold-off on request, counted here in its own cycles.
  initial begin : receiver
    int run_len;
    int stall_len;
    int hold_left;
    run_len   = 0;
    stall_len = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len <= 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_free) begin
        out_ready <= 1'b1;
      end else if (run_len > 0) begin
        out_ready <= 1'b1;
        run_len--;
      end else if (stall_len > 0) begin
        out_ready <= 1'b0;
        stall_len--;
      end else begin
        run_len   = $urandom_range(1, 24);
        stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
        out_ready <= 1'b1;
      end
    end
  end

  // Every word taken at the output is compared with the oldest owed word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{key: out_sorted_key, payload: out_sorted_payload, last: out_last_out};
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected output word key=%h payload=%h last=%b",
                             got_word.key, got_word.payload, got_word.last));
      end else begin
        want_word = expected_words.pop_front();
        if (got_word !== want_word) begin
          flag_error($sformatf("expected key=%h pay=%h last=%b, got key=%h pay=%h last=%b",
                               want_word.key, want_word.payload, want_word.last,
                               got_word.key, got_word.payload, got_word.last));
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("stable_counting_sort_core_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_limit();
    test_limit_extremes();
    test_unmapped_register();
    test_clamp_at_load();
    test_batch_overflow();
    test_output_backpressure();
    test_random_batches();
    wait_drained();
    repeat (END_QUIET) @(posedge clk);
    if (expected_words.size() != 0) begin
      flag_error($sformatf("%0d output words never arrived", expected_words.size()));
    end
    if (error_count == 0) begin
      $display("stable_counting_sort_core_tb: done, clean");
    end else begin
      $display("stable_counting_sort_core_tb: done, errors");
    end
    $finish;
  end

endmodule
